[rtl/core/dzt_pkg.sv]
// ----------------------------------------------------------------------------
// dzt_pkg
// Shared types and constants for the dual-zone touch stick and tap block.
// ----------------------------------------------------------------------------
package dzt_pkg;

  localparam int REQ_W      = 2;
  localparam int ID_W       = 32;
  localparam int POS_W      = 12;
  localparam int TIME_W     = 64;
  localparam int AXIS_W     = 16;
  localparam int TURN_W     = 37;
  localparam int TRAVEL_W   = 16;
  localparam int TURN_PIX_W = 20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PAD_RADIUS_DEF = 70;

  // Reciprocal shift for the deflection scale: numerator below 2^26,
  // radius below 2^12.
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int Q14_SHIFT   = 14;

  localparam logic [AXIS_W-2:0] Q14_ONE = 15'd16384;

  typedef enum logic [REQ_W-1:0] {
    REQ_DOWN    = 2'd0,
    REQ_MOVE    = 2'd1,
    REQ_UP      = 2'd2,
    REQ_CONSUME = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_SPLIT  = 3'd0,
    CFG_DEAD_ZONE   = 3'd1,
    CFG_TAP_TRAVEL  = 3'd2,
    CFG_TAP_TIME    = 3'd3,
    CFG_TURN_GAIN   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]    zone_split;
    logic [7:0]          dead_zone;
    logic [TRAVEL_W-1:0] tap_travel_limit;
    logic [31:0]         tap_time_limit;
    logic [15:0]         turn_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zone_split:       12'd1024,
    dead_zone:        8'd10,
    tap_travel_limit: 16'd14,
    tap_time_limit:   32'd260000,
    turn_gain:        16'd492
  };

endpackage

[rtl/core/dzt_in_if.sv]
// ----------------------------------------------------------------------------
// dzt_in_if
// Touch request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface dzt_in_if;
  import dzt_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ID_W-1:0]   touch_id;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, req_type, touch_id, pos_x, pos_y, time_us, input ready);
  modport sink   (input valid, req_type, touch_id, pos_x, pos_y, time_us, output ready);

endinterface

[rtl/core/dzt_out_if.sv]
// ----------------------------------------------------------------------------
// dzt_out_if
// Control result channel: valid/ready handshake with drive, turn and fire.
// ----------------------------------------------------------------------------
interface dzt_out_if;
  import dzt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] forward;
  logic signed [AXIS_W-1:0] strafe;
  logic signed [TURN_W-1:0] turn;
  logic                     fire;

  modport source (output valid, forward, strafe, turn, fire, input ready);
  modport sink   (input valid, forward, strafe, turn, fire, output ready);

endinterface

[rtl/core/dual_zone_touch_stick_and_tap.sv]
// ----------------------------------------------------------------------------
// dual_zone_touch_stick_and_tap
// Virtual stick on the left zone, look and tap on the right zone.
// ----------------------------------------------------------------------------
// Takes one touch request per cycle while no consume request is held
// back. A request is captured in an input register; down, move and up
// requests are applied to the finger state in the following cycle, and a
// consume request loads the result register as it leaves the input
// register. The state update is the only loop, so down, move and up
// requests flow at full rate; a consume request waits in the input
// register, and holds off the input, only while the result register
// still holds an untaken result. Configuration writes take effect at
// the next edge and are meant to happen while idle.
module dual_zone_touch_stick_and_tap #(
  parameter int PAD_RADIUS = dzt_pkg::PAD_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dzt_in_if.sink                           in_ch,
  dzt_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dzt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dzt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dzt_pkg::*;

  localparam logic signed [TURN_PIX_W-1:0] TURN_PIX_MAX = {1'b0, {(TURN_PIX_W-1){1'b1}}};
  localparam logic signed [TURN_PIX_W-1:0] TURN_PIX_MIN = {1'b1, {(TURN_PIX_W-1){1'b0}}};

  // configuration
  cfg_t cfg_r;

  // input register
  logic              s1_valid_r;
  req_t              s1_req_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [POS_W-1:0]  s1_x_r;
  logic [POS_W-1:0]  s1_y_r;
  logic [TIME_W-1:0] s1_time_r;

  // finger state
  logic                         stick_active_r, stick_active_nxt;
  logic [ID_W-1:0]              stick_finger_r, stick_finger_nxt;
  logic [POS_W-1:0]             stick_pos_x_r, stick_pos_x_nxt;
  logic [POS_W-1:0]             stick_pos_y_r, stick_pos_y_nxt;
  logic [POS_W-1:0]             stick_origin_x_r, stick_origin_x_nxt;
  logic [POS_W-1:0]             stick_origin_y_r, stick_origin_y_nxt;
  logic                         look_active_r, look_active_nxt;
  logic [ID_W-1:0]              look_finger_r, look_finger_nxt;
  logic [POS_W-1:0]             look_pos_x_r, look_pos_x_nxt;
  logic [POS_W-1:0]             look_pos_y_r, look_pos_y_nxt;
  logic [TIME_W-1:0]            look_start_r, look_start_nxt;
  logic [TRAVEL_W-1:0]          look_travel_r, look_travel_nxt;
  logic signed [TURN_PIX_W-1:0] turn_pixels_r, turn_pixels_nxt;
  logic                         tap_pending_r, tap_pending_nxt;

  // result register
  logic                     out_valid_r;
  logic signed [AXIS_W-1:0] out_forward_r;
  logic signed [AXIS_W-1:0] out_strafe_r;
  logic signed [TURN_W-1:0] out_turn_r;
  logic                     out_fire_r;

  logic in_ready;
  logic in_xfer;
  logic out_free;
  logic s1_fire;
  logic s1_consume;
  logic stick_hit;
  logic look_hit;

  logic signed [POS_W:0]        look_dx;
  logic signed [POS_W:0]        look_dy;
  logic [POS_W-1:0]             abs_dx;
  logic [POS_W-1:0]             abs_dy;
  logic [TRAVEL_W+1:0]          travel_sum;
  logic signed [TURN_PIX_W:0]   turn_sum;
  logic [TIME_W-1:0]            hold_time;
  logic                         tap_ok;

  logic signed [POS_W:0]        stick_dx;
  logic signed [POS_W:0]        stick_dy;
  logic signed [AXIS_W-1:0]     defl_x;
  logic signed [AXIS_W-1:0]     defl_y;
  logic signed [16:0]           gain_s;
  logic signed [TURN_W-1:0]     turn_prod;

  // ---------------------------------------------------------------- handshake
  assign s1_consume = (s1_req_r == REQ_CONSUME);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_fire    = s1_valid_r && (!s1_consume || out_free);
  assign in_ready   = !s1_valid_r || s1_fire;
  assign in_xfer    = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZONE_SPLIT: cfg_r.zone_split       <= cfg_data[POS_W-1:0];
        CFG_DEAD_ZONE:  cfg_r.dead_zone        <= cfg_data[7:0];
        CFG_TAP_TRAVEL: cfg_r.tap_travel_limit <= cfg_data[TRAVEL_W-1:0];
        CFG_TAP_TIME:   cfg_r.tap_time_limit   <= cfg_data[31:0];
        CFG_TURN_GAIN:  cfg_r.turn_gain        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r  <= req_t'(in_ch.req_type);
      s1_id_r   <= in_ch.touch_id;
      s1_x_r    <= in_ch.pos_x;
      s1_y_r    <= in_ch.pos_y;
      s1_time_r <= in_ch.time_us;
    end
  end

  // ---------------------------------------------------------------- look motion
  assign look_dx    = $signed({1'b0, s1_x_r}) - $signed({1'b0, look_pos_x_r});
  assign look_dy    = $signed({1'b0, s1_y_r}) - $signed({1'b0, look_pos_y_r});
  assign abs_dx     = look_dx[POS_W] ? POS_W'(-look_dx) : look_dx[POS_W-1:0];
  assign abs_dy     = look_dy[POS_W] ? POS_W'(-look_dy) : look_dy[POS_W-1:0];
  assign travel_sum = {2'b00, look_travel_r}
                    + {{(TRAVEL_W+2-POS_W){1'b0}}, abs_dx}
                    + {{(TRAVEL_W+2-POS_W){1'b0}}, abs_dy};
  assign turn_sum   = {turn_pixels_r[TURN_PIX_W-1], turn_pixels_r}
                    + {{(TURN_PIX_W-POS_W){look_dx[POS_W]}}, look_dx};
  assign hold_time  = s1_time_r - look_start_r;
  assign tap_ok     = (look_travel_r < cfg_r.tap_travel_limit)
                   && (hold_time < {32'd0, cfg_r.tap_time_limit});

  assign stick_hit = stick_active_r && (stick_finger_r == s1_id_r);
  assign look_hit  = look_active_r && (look_finger_r == s1_id_r);

  // ---------------------------------------------------------------- state update
  always_comb begin
    stick_active_nxt   = stick_active_r;
    stick_finger_nxt   = stick_finger_r;
    stick_pos_x_nxt    = stick_pos_x_r;
    stick_pos_y_nxt    = stick_pos_y_r;
    stick_origin_x_nxt = stick_origin_x_r;
    stick_origin_y_nxt = stick_origin_y_r;
    look_active_nxt    = look_active_r;
    look_finger_nxt    = look_finger_r;
    look_pos_x_nxt     = look_pos_x_r;
    look_pos_y_nxt     = look_pos_y_r;
    look_start_nxt     = look_start_r;
    look_travel_nxt    = look_travel_r;
    turn_pixels_nxt    = turn_pixels_r;
    tap_pending_nxt    = tap_pending_r;
    if (s1_fire) begin
      unique case (s1_req_r)
        REQ_DOWN: begin
          if (s1_x_r < cfg_r.zone_split) begin
            if (!stick_active_r) begin
              stick_active_nxt   = 1'b1;
              stick_finger_nxt   = s1_id_r;
              stick_pos_x_nxt    = s1_x_r;
              stick_pos_y_nxt    = s1_y_r;
              stick_origin_x_nxt = s1_x_r;
              stick_origin_y_nxt = s1_y_r;
            end
          end else if (!look_active_r) begin
            look_active_nxt = 1'b1;
            look_finger_nxt = s1_id_r;
            look_pos_x_nxt  = s1_x_r;
            look_pos_y_nxt  = s1_y_r;
            look_start_nxt  = s1_time_r;
            look_travel_nxt = '0;
          end
        end
        REQ_MOVE: begin
          if (stick_hit) begin
            stick_pos_x_nxt = s1_x_r;
            stick_pos_y_nxt = s1_y_r;
          end else if (look_hit) begin
            look_travel_nxt = (travel_sum[TRAVEL_W+1:TRAVEL_W] != 2'b00) ?
                              {TRAVEL_W{1'b1}} : travel_sum[TRAVEL_W-1:0];
            if (turn_sum[TURN_PIX_W] != turn_sum[TURN_PIX_W-1]) begin
              turn_pixels_nxt = turn_sum[TURN_PIX_W] ? TURN_PIX_MIN : TURN_PIX_MAX;
            end else begin
              turn_pixels_nxt = turn_sum[TURN_PIX_W-1:0];
            end
            look_pos_x_nxt = s1_x_r;
            look_pos_y_nxt = s1_y_r;
          end
        end
        REQ_UP: begin
          if (stick_hit) begin
            stick_active_nxt = 1'b0;
          end else if (look_hit) begin
            if (tap_ok) begin
              tap_pending_nxt = 1'b1;
            end
            look_active_nxt = 1'b0;
          end
        end
        REQ_CONSUME: begin
          turn_pixels_nxt = '0;
          tap_pending_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_active_r   <= 1'b0;
      stick_finger_r   <= '0;
      stick_pos_x_r    <= '0;
      stick_pos_y_r    <= '0;
      stick_origin_x_r <= '0;
      stick_origin_y_r <= '0;
      look_active_r    <= 1'b0;
      look_finger_r    <= '0;
      look_pos_x_r     <= '0;
      look_pos_y_r     <= '0;
      look_start_r     <= '0;
      look_travel_r    <= '0;
      turn_pixels_r    <= '0;
      tap_pending_r    <= 1'b0;
    end else begin
      stick_active_r   <= stick_active_nxt;
      stick_finger_r   <= stick_finger_nxt;
      stick_pos_x_r    <= stick_pos_x_nxt;
      stick_pos_y_r    <= stick_pos_y_nxt;
      stick_origin_x_r <= stick_origin_x_nxt;
      stick_origin_y_r <= stick_origin_y_nxt;
      look_active_r    <= look_active_nxt;
      look_finger_r    <= look_finger_nxt;
      look_pos_x_r     <= look_pos_x_nxt;
      look_pos_y_r     <= look_pos_y_nxt;
      look_start_r     <= look_start_nxt;
      look_travel_r    <= look_travel_nxt;
      turn_pixels_r    <= turn_pixels_nxt;
      tap_pending_r    <= tap_pending_nxt;
    end
  end

  // ---------------------------------------------------------------- consume result
  assign stick_dx = $signed({1'b0, stick_pos_x_r}) - $signed({1'b0, stick_origin_x_r});
  assign stick_dy = $signed({1'b0, stick_pos_y_r}) - $signed({1'b0, stick_origin_y_r});

  dzt_deflect #(.PAD_RADIUS(PAD_RADIUS)) u_defl_x (
    .delta     (stick_dx),
    .dead_zone (cfg_r.dead_zone),
    .defl      (defl_x)
  );

  dzt_deflect #(.PAD_RADIUS(PAD_RADIUS)) u_defl_y (
    .delta     (stick_dy),
    .dead_zone (cfg_r.dead_zone),
    .defl      (defl_y)
  );

  assign gain_s    = $signed({1'b0, cfg_r.turn_gain});
  assign turn_prod = TURN_W'(turn_pixels_r) * TURN_W'(gain_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_consume) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_consume) begin
      out_forward_r <= stick_active_r ? -defl_y : '0;
      out_strafe_r  <= stick_active_r ? defl_x : '0;
      out_turn_r    <= turn_prod;
      out_fire_r    <= tap_pending_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.forward = out_forward_r;
  assign out_ch.strafe  = out_strafe_r;
  assign out_ch.turn    = out_turn_r;
  assign out_ch.fire    = out_fire_r;

  // ---------------------------------------------------------------- assertions
  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_consume |=> (turn_pixels_r == '0) && !tap_pending_r)
    else $error("consume did not clear turn accumulator and tap");

  a_travel_grows: assert property (@(posedge clk) disable iff (!rst_n)
    look_active_r && $past(look_active_r) |-> look_travel_r >= $past(look_travel_r))
    else $error("look travel decreased while the look finger was held");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_consume_waits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_consume && out_valid_r && !out_ch.ready |-> !in_ready)
    else $error("input taken while a consume request is blocked");

endmodule

[rtl/core/dzt_deflect.sv]
// ----------------------------------------------------------------------------
// dzt_deflect
// Stick axis deflection: dead zone, scale by 16384/radius toward zero, clamp.
// ----------------------------------------------------------------------------
module dzt_deflect #(
  parameter int PAD_RADIUS = dzt_pkg::PAD_RADIUS_DEF
) (
  input  logic signed [dzt_pkg::POS_W:0]    delta,
  input  logic        [7:0]                 dead_zone,
  output logic signed [dzt_pkg::AXIS_W-1:0] defl
);
  import dzt_pkg::*;

  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SHIFT) + longint'(PAD_RADIUS) - 1) / longint'(PAD_RADIUS);
  localparam logic [RECIP_W-1:0]   RECIP  = RECIP_L[RECIP_W-1:0];
  localparam logic [POS_W-1:0]     RADIUS = POS_W'(PAD_RADIUS);
  localparam int                   PROD_W = POS_W + RECIP_W;
  localparam int                   Q_LSB  = RECIP_SHIFT - Q14_SHIFT;

  logic [POS_W:0]        delta_abs;
  logic [POS_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic [AXIS_W-2:0]     mag_q;

  assign delta_abs = delta[POS_W] ? (~delta + 1'b1) : delta;
  assign mag       = delta_abs[POS_W-1:0];
  assign prod      = {{RECIP_W{1'b0}}, mag} * {{POS_W{1'b0}}, RECIP};

  always_comb begin
    if (mag < {{(POS_W-8){1'b0}}, dead_zone}) begin
      mag_q = '0;
    end else if (mag >= RADIUS) begin
      mag_q = Q14_ONE;
    end else begin
      mag_q = {1'b0, prod[Q_LSB +: Q14_SHIFT]};
    end
  end

  assign defl = delta[POS_W] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule
